// ===== sv/pwtb_pkg.sv =====
package pwtb_pkg;

    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int MAX_WAIT_NS_DEF = 1000000000;

    localparam logic [31:0] NS_PER_S = 32'd1000000000;
    localparam int KIB_SHIFT  = 10;
    localparam int MUL_STEPS  = 32;
    localparam int DIV_STEPS  = 64;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_ACTIVE = 2'd1;
    localparam logic [1:0] REG_RATE   = 2'd2;

    typedef enum logic [1:0] {
        CMD_REQ      = 2'd0,
        CMD_RELOAD   = 2'd1,
        CMD_WAITDONE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        DEC_PASS     = 3'd0,
        DEC_OFF      = 3'd1,
        DEC_INV_FG   = 3'd2,
        DEC_FG       = 3'd3,
        DEC_GRANT    = 3'd4,
        DEC_WAIT     = 3'd5,
        DEC_ACK      = 3'd6
    } decision_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_REFILL,
        S_FULL_DIV,
        S_FULL_REM,
        S_FULL_CMP,
        S_ADD_DIV,
        S_ADD,
        S_ADV_DIV,
        S_ADV,
        S_TAKE,
        S_WAIT_DIV,
        S_WAIT_REM,
        S_WAIT_FIN,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

endpackage

// ===== sv/page_write_token_bucket_top.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    command .. waited_ns
// out       output     out_valid / out_ready  decision .. total_wait_ns
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// One word is processed at a time. A word that is not a throttled page request
// passes from idle through the execute and output states back to idle. A
// throttled page request may run up to four bit-serial multiplications and
// six restoring divisions before it returns through the output state to idle.
// The result register frees the input side once a result is stored there;
// a stalled output holds the next result in the last state.
// Reset clears the bucket, the statistics and the configuration registers to zero.
module page_write_token_bucket_top #(
    parameter int PAGE_BYTES  = pwtb_pkg::PAGE_BYTES_DEF,
    parameter int MAX_WAIT_NS = pwtb_pkg::MAX_WAIT_NS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [63:0]        now_ns,
    input  logic [31:0]        requester_uid,
    input  logic signed [31:0] foreground_uid,
    input  logic               is_background,
    input  logic [63:0]        waited_ns,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         decision,
    output logic [29:0]        wait_ns,
    output logic [28:0]        tokens_left,
    output logic [63:0]        charged_bytes,
    output logic [63:0]        wait_events,
    output logic [63:0]        fg_bypasses,
    output logic [63:0]        invalid_fg_bypasses,
    output logic [63:0]        total_wait_ns
);

    localparam logic [28:0] PAGE = 29'(PAGE_BYTES);
    localparam logic [29:0] WMAX = 30'(MAX_WAIT_NS);

    pwtb_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic        enable_reg, active_reg;
    logic [21:0] rate_kib_reg;
    logic [31:0] rate_reg, rate_next;
    logic [28:0] burst_reg, burst_next, tokens_reg, tokens_next;
    logic [63:0] last_reg, last_next;
    logic [63:0] granted_reg, granted_next, waitcnt_reg, waitcnt_next;
    logic [63:0] fgcnt_reg, fgcnt_next, invcnt_reg, invcnt_next;
    logic [63:0] waitsum_reg, waitsum_next;
    logic        out_valid_reg, out_valid_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [1:0]  cmd_reg;
    logic [63:0] now_reg, waited_reg;
    logic [31:0] uid_reg, fg_reg;
    logic        bg_reg;

    logic [63:0] ma_reg, ma_next, acc_reg, acc_next, dq_reg, dq_next;
    logic [31:0] mb_reg, mb_next, dd_reg, dd_next, dr_reg, dr_next;
    logic [63:0] elapsed_reg, elapsed_next, tmp_reg, tmp_next;
    logic [28:0] missing_reg, missing_next;
    pwtb_pkg::decision_t dec_reg, dec_next;
    logic [29:0] wait_reg, wait_next;

    logic [2:0]  o_dec_reg;
    logic [29:0] o_wait_reg;
    logic [28:0] o_tok_reg;
    logic [63:0] o_gr_reg, o_wc_reg, o_fg_reg, o_inv_reg, o_ws_reg;

    logic        limiter_on, fg_unknown, fg_match, throttle;
    logic        refill_skip, tok_enough, elapsed_done, added_zero, added_cover;
    logic [64:0] full_ns;
    logic        out_load;

    assign limiter_on  = enable_reg && active_reg && (rate_reg != 32'd0);
    assign fg_unknown  = fg_reg[31];
    assign fg_match    = (fg_reg == uid_reg);
    assign throttle    = (cmd_reg == pwtb_pkg::CMD_REQ) && limiter_on && !fg_unknown
                         && !fg_match && bg_reg;
    assign refill_skip = (rate_reg == 32'd0) || (burst_reg == 29'd0)
                         || (tokens_reg >= burst_reg) || (now_reg <= last_reg);
    assign full_ns      = {1'b0, tmp_reg} + {64'd0, (dr_reg != 32'd0)};
    assign elapsed_done = {1'b0, elapsed_reg} >= full_ns;
    assign added_zero   = (dq_reg == 64'd0);
    assign added_cover  = (dq_reg >= {35'd0, missing_reg});
    assign tok_enough   = (tokens_reg >= PAGE);
    assign out_load     = (state_reg == pwtb_pkg::S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwtb_pkg::S_IDLE:     if (in_valid) state_next = pwtb_pkg::S_EXEC;
            pwtb_pkg::S_EXEC:     state_next = throttle ? pwtb_pkg::S_REFILL : pwtb_pkg::S_OUT;
            pwtb_pkg::S_REFILL:   state_next = refill_skip ? pwtb_pkg::S_TAKE : pwtb_pkg::S_MUL;
            pwtb_pkg::S_FULL_DIV: state_next = pwtb_pkg::S_DIV;
            pwtb_pkg::S_FULL_REM: state_next = pwtb_pkg::S_DIV;
            pwtb_pkg::S_FULL_CMP: state_next = elapsed_done ? pwtb_pkg::S_TAKE : pwtb_pkg::S_MUL;
            pwtb_pkg::S_ADD_DIV:  state_next = pwtb_pkg::S_DIV;
            pwtb_pkg::S_ADD:
                state_next = (added_zero || added_cover) ? pwtb_pkg::S_TAKE : pwtb_pkg::S_MUL;
            pwtb_pkg::S_ADV_DIV:  state_next = pwtb_pkg::S_DIV;
            pwtb_pkg::S_ADV:      state_next = pwtb_pkg::S_TAKE;
            pwtb_pkg::S_TAKE:     state_next = tok_enough ? pwtb_pkg::S_OUT : pwtb_pkg::S_MUL;
            pwtb_pkg::S_WAIT_DIV: state_next = pwtb_pkg::S_DIV;
            pwtb_pkg::S_WAIT_REM: state_next = pwtb_pkg::S_DIV;
            pwtb_pkg::S_WAIT_FIN: state_next = pwtb_pkg::S_OUT;
            pwtb_pkg::S_MUL:
                if (cnt_reg == 6'(pwtb_pkg::MUL_STEPS - 1)) state_next = ret_reg;
            pwtb_pkg::S_DIV:
                if (cnt_reg == 6'(pwtb_pkg::DIV_STEPS - 1)) state_next = ret_reg;
            pwtb_pkg::S_OUT:      if (out_load) state_next = pwtb_pkg::S_IDLE;
            default:              state_next = pwtb_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        logic [32:0] dtrial;
        logic        dge;
        logic [64:0] sum65;
        logic [63:0] adv;
        logic [31:0] r;
        logic [28:0] b;

        dtrial = {dr_reg, dq_reg[63]};
        dge    = dtrial >= {1'b0, dd_reg};
        sum65  = 65'd0;
        adv    = 64'd0;
        r      = 32'd0;
        b      = 29'd0;

        ret_next     = ret_reg;
        rate_next    = rate_reg;
        burst_next   = burst_reg;
        tokens_next  = tokens_reg;
        last_next    = last_reg;
        granted_next = granted_reg;
        waitcnt_next = waitcnt_reg;
        fgcnt_next   = fgcnt_reg;
        invcnt_next  = invcnt_reg;
        waitsum_next = waitsum_reg;
        cnt_next     = cnt_reg + 6'd1;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        acc_next     = acc_reg;
        dq_next      = dq_reg;
        dd_next      = dd_reg;
        dr_next      = dr_reg;
        elapsed_next = elapsed_reg;
        tmp_next     = tmp_reg;
        missing_next = missing_reg;
        dec_next     = dec_reg;
        wait_next    = wait_reg;

        case (state_reg)
            pwtb_pkg::S_EXEC:
            begin
                dec_next  = pwtb_pkg::DEC_ACK;
                wait_next = 30'd0;
                case (cmd_reg)
                    pwtb_pkg::CMD_REQ:
                        if (!limiter_on)
                            dec_next = pwtb_pkg::DEC_OFF;
                        else if (fg_unknown)
                        begin
                            dec_next    = pwtb_pkg::DEC_INV_FG;
                            invcnt_next = (&invcnt_reg) ? invcnt_reg : invcnt_reg + 64'd1;
                        end
                        else if (fg_match)
                        begin
                            dec_next   = pwtb_pkg::DEC_FG;
                            fgcnt_next = (&fgcnt_reg) ? fgcnt_reg : fgcnt_reg + 64'd1;
                        end
                        else if (!bg_reg)
                            dec_next = pwtb_pkg::DEC_PASS;
                    pwtb_pkg::CMD_RELOAD:
                    begin
                        r = (enable_reg && active_reg) ? {rate_kib_reg, 10'd0} : 32'd0;
                        if (r == 32'd0)
                            b = 29'd0;
                        else
                            b = (r[31:3] < PAGE) ? PAGE : r[31:3];
                        rate_next   = r;
                        burst_next  = b;
                        tokens_next = b;
                        last_next   = now_reg;
                    end
                    pwtb_pkg::CMD_WAITDONE:
                    begin
                        sum65 = {1'b0, waitsum_reg} + {1'b0, waited_reg};
                        waitsum_next = sum65[64] ? {64{1'b1}} : sum65[63:0];
                    end
                    default: ;
                endcase
            end
            pwtb_pkg::S_REFILL:
                if (rate_reg != 32'd0 && burst_reg != 29'd0)
                begin
                    if (tokens_reg >= burst_reg)
                    begin
                        tokens_next = burst_reg;
                        last_next   = now_reg;
                    end
                    else if (now_reg > last_reg)
                    begin
                        elapsed_next = now_reg - last_reg;
                        missing_next = burst_reg - tokens_reg;
                        ma_next  = {35'd0, burst_reg - tokens_reg};
                        mb_next  = pwtb_pkg::NS_PER_S;
                        acc_next = 64'd0;
                        cnt_next = 6'd0;
                        ret_next = pwtb_pkg::S_FULL_DIV;
                    end
                end
            pwtb_pkg::S_FULL_DIV, pwtb_pkg::S_ADV_DIV, pwtb_pkg::S_WAIT_DIV:
            begin
                dq_next  = acc_reg;
                dd_next  = rate_reg;
                dr_next  = 32'd0;
                cnt_next = 6'd0;
                ret_next = (state_reg == pwtb_pkg::S_FULL_DIV) ? pwtb_pkg::S_FULL_REM :
                           (state_reg == pwtb_pkg::S_ADV_DIV)  ? pwtb_pkg::S_ADV :
                                                                 pwtb_pkg::S_WAIT_REM;
            end
            pwtb_pkg::S_FULL_REM, pwtb_pkg::S_WAIT_REM:
            begin
                tmp_next = dq_reg;
                dq_next  = {35'd0, missing_reg};
                dd_next  = rate_reg;
                dr_next  = 32'd0;
                cnt_next = 6'd0;
                ret_next = (state_reg == pwtb_pkg::S_FULL_REM) ? pwtb_pkg::S_FULL_CMP
                                                              : pwtb_pkg::S_WAIT_FIN;
            end
            pwtb_pkg::S_FULL_CMP:
                if (elapsed_done)
                begin
                    tokens_next = burst_reg;
                    last_next   = now_reg;
                end
                else
                begin
                    ma_next  = elapsed_reg;
                    mb_next  = rate_reg;
                    acc_next = 64'd0;
                    cnt_next = 6'd0;
                    ret_next = pwtb_pkg::S_ADD_DIV;
                end
            pwtb_pkg::S_ADD_DIV:
            begin
                dq_next  = acc_reg;
                dd_next  = pwtb_pkg::NS_PER_S;
                dr_next  = 32'd0;
                cnt_next = 6'd0;
                ret_next = pwtb_pkg::S_ADD;
            end
            pwtb_pkg::S_ADD:
                if (!added_zero)
                begin
                    if (added_cover)
                    begin
                        tokens_next = burst_reg;
                        last_next   = now_reg;
                    end
                    else
                    begin
                        // The added count is below the missing bytes here.
                        tokens_next = tokens_reg + dq_reg[28:0];
                        ma_next  = dq_reg;
                        mb_next  = pwtb_pkg::NS_PER_S;
                        acc_next = 64'd0;
                        cnt_next = 6'd0;
                        ret_next = pwtb_pkg::S_ADV_DIV;
                    end
                end
            pwtb_pkg::S_ADV:
            begin
                adv   = added_zero ? 64'd1 : dq_reg;
                sum65 = {1'b0, last_reg} + {1'b0, adv};
                adv   = sum65[64] ? {64{1'b1}} : sum65[63:0];
                last_next = (now_reg < adv) ? now_reg : adv;
            end
            pwtb_pkg::S_TAKE:
                if (tok_enough)
                begin
                    tokens_next  = tokens_reg - PAGE;
                    sum65        = {1'b0, granted_reg} + {36'd0, PAGE};
                    granted_next = sum65[64] ? {64{1'b1}} : sum65[63:0];
                    dec_next     = pwtb_pkg::DEC_GRANT;
                end
                else
                begin
                    missing_next = PAGE - tokens_reg;
                    ma_next  = {35'd0, PAGE - tokens_reg};
                    mb_next  = pwtb_pkg::NS_PER_S;
                    acc_next = 64'd0;
                    cnt_next = 6'd0;
                    ret_next = pwtb_pkg::S_WAIT_DIV;
                end
            pwtb_pkg::S_WAIT_FIN:
            begin
                wait_next    = (full_ns > {35'd0, WMAX}) ? WMAX : full_ns[29:0];
                waitcnt_next = (&waitcnt_reg) ? waitcnt_reg : waitcnt_reg + 64'd1;
                dec_next     = pwtb_pkg::DEC_WAIT;
            end
            pwtb_pkg::S_MUL:
            begin
                // One bit of the multiplier per cycle, least significant first.
                acc_next = acc_reg + (mb_reg[0] ? ma_reg : 64'd0);
                ma_next  = {ma_reg[62:0], 1'b0};
                mb_next  = {1'b0, mb_reg[31:1]};
            end
            pwtb_pkg::S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                dr_next = dge ? 32'(dtrial - {1'b0, dd_reg}) : dtrial[31:0];
                dq_next = {dq_reg[62:0], dge};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwtb_pkg::S_IDLE;
            ret_reg       <= pwtb_pkg::S_IDLE;
            enable_reg    <= 1'b0;
            active_reg    <= 1'b0;
            rate_kib_reg  <= 22'd0;
            rate_reg      <= 32'd0;
            burst_reg     <= 29'd0;
            tokens_reg    <= 29'd0;
            last_reg      <= 64'd0;
            granted_reg   <= 64'd0;
            waitcnt_reg   <= 64'd0;
            fgcnt_reg     <= 64'd0;
            invcnt_reg    <= 64'd0;
            waitsum_reg   <= 64'd0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 6'd0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            rate_reg      <= rate_next;
            burst_reg     <= burst_next;
            tokens_reg    <= tokens_next;
            last_reg      <= last_next;
            granted_reg   <= granted_next;
            waitcnt_reg   <= waitcnt_next;
            fgcnt_reg     <= fgcnt_next;
            invcnt_reg    <= invcnt_next;
            waitsum_reg   <= waitsum_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pwtb_pkg::REG_ENABLE: enable_reg   <= cfg_data[0];
                    pwtb_pkg::REG_ACTIVE: active_reg   <= cfg_data[0];
                    pwtb_pkg::REG_RATE:   rate_kib_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg    <= command;
            now_reg    <= now_ns;
            uid_reg    <= requester_uid;
            fg_reg     <= $unsigned(foreground_uid);
            bg_reg     <= is_background;
            waited_reg <= waited_ns;
        end
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        acc_reg     <= acc_next;
        dq_reg      <= dq_next;
        dd_reg      <= dd_next;
        dr_reg      <= dr_next;
        elapsed_reg <= elapsed_next;
        tmp_reg     <= tmp_next;
        missing_reg <= missing_next;
        dec_reg     <= dec_next;
        wait_reg    <= wait_next;
        if (out_load)
        begin
            o_dec_reg  <= dec_reg;
            o_wait_reg <= wait_reg;
            o_tok_reg  <= tokens_reg;
            o_gr_reg   <= granted_reg;
            o_wc_reg   <= waitcnt_reg;
            o_fg_reg   <= fgcnt_reg;
            o_inv_reg  <= invcnt_reg;
            o_ws_reg   <= waitsum_reg;
        end
    end

    assign in_ready            = (state_reg == pwtb_pkg::S_IDLE);
    assign out_valid           = out_valid_reg;
    assign decision            = o_dec_reg;
    assign wait_ns             = o_wait_reg;
    assign tokens_left         = o_tok_reg;
    assign charged_bytes       = o_gr_reg;
    assign wait_events         = o_wc_reg;
    assign fg_bypasses         = o_fg_reg;
    assign invalid_fg_bypasses = o_inv_reg;
    assign total_wait_ns       = o_ws_reg;

endmodule

// ===== tb/token_bucket_checker.sv =====
`timescale 1ns / 1ps

module token_bucket_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         command,
    input  logic [63:0]        now_ns,
    input  logic [31:0]        requester_uid,
    input  logic signed [31:0] foreground_uid,
    input  logic               is_background,
    input  logic [63:0]        waited_ns,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         decision,
    input  logic [29:0]        wait_ns,
    input  logic [28:0]        tokens_left,
    input  logic [63:0]        charged_bytes,
    input  logic [63:0]        wait_events,
    input  logic [63:0]        fg_bypasses,
    input  logic [63:0]        invalid_fg_bypasses,
    input  logic [63:0]        total_wait_ns,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    localparam logic [63:0] ONE_SECOND = {32'd0, pwtb_pkg::NS_PER_S};
    localparam logic [63:0] PAGE       = 64'(pwtb_pkg::PAGE_BYTES_DEF);
    localparam logic [63:0] WAIT_CAP   = 64'(pwtb_pkg::MAX_WAIT_NS_DEF);

    typedef struct {
        logic [2:0]  dec;
        logic [29:0] sleep;
        logic [28:0] tokens;
        logic [63:0] charged;
        logic [63:0] waits;
        logic [63:0] fg_count;
        logic [63:0] inv_count;
        logic [63:0] slept;
    } bucket_result_t;

    bucket_result_t expected_results[$];

    logic        limiter_en, limit_active;
    logic [21:0] rate_kib;
    logic [63:0] byte_rate, burst, tokens, refill_stamp;
    logic [63:0] granted, wait_count, fg_total, inv_total, slept_total;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        return (64'hFFFF_FFFF_FFFF_FFFF - a < b) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
    endfunction

    function automatic logic [63:0] ns_to_gather(logic [63:0] bytes, logic [63:0] rate,
                                                 bit ceil_mode);
        logic [63:0] secs, rem, t;
        if (rate == 0)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        secs = bytes / rate;
        rem = bytes % rate;
        t = sat_add(secs * ONE_SECOND, (rem * ONE_SECOND) / rate);
        if (ceil_mode && rem != 0)
            t = sat_add(t, 64'd1);
        return t;
    endfunction

    task automatic top_up(logic [63:0] now);
        logic [63:0] elapsed, missing, added, adv;
        if (byte_rate == 0 || burst == 0)
            return;
        if (tokens >= burst)
        begin
            tokens = burst;
            refill_stamp = now;
            return;
        end
        if (now <= refill_stamp)
            return;
        elapsed = now - refill_stamp;
        missing = burst - tokens;
        if (elapsed >= ns_to_gather(missing, byte_rate, 1'b1))
        begin
            tokens = burst;
            refill_stamp = now;
            return;
        end
        added = (elapsed * byte_rate) / ONE_SECOND;
        if (added == 0)
            return;
        if (added >= missing)
        begin
            tokens = burst;
            refill_stamp = now;
            return;
        end
        tokens = tokens + added;
        adv = ns_to_gather(added, byte_rate, 1'b0);
        if (adv < 1)
            adv = 1;
        adv = sat_add(refill_stamp, adv);
        refill_stamp = (now < adv) ? now : adv;
    endtask

    task automatic bucket_step(output bucket_result_t r);
        logic [63:0] sleep;
        logic [2:0]  dec;
        sleep = 0;
        dec = pwtb_pkg::DEC_ACK;
        case (command)
            pwtb_pkg::CMD_REQ:
            begin
                if (!(limiter_en && limit_active && byte_rate != 0))
                    dec = pwtb_pkg::DEC_OFF;
                else if (foreground_uid[31])
                begin
                    inv_total = sat_add(inv_total, 64'd1);
                    dec = pwtb_pkg::DEC_INV_FG;
                end
                else if ($unsigned(foreground_uid) == requester_uid)
                begin
                    fg_total = sat_add(fg_total, 64'd1);
                    dec = pwtb_pkg::DEC_FG;
                end
                else if (!is_background)
                    dec = pwtb_pkg::DEC_PASS;
                else
                begin
                    top_up(now_ns);
                    if (tokens >= PAGE)
                    begin
                        tokens = tokens - PAGE;
                        granted = sat_add(granted, PAGE);
                        dec = pwtb_pkg::DEC_GRANT;
                    end
                    else
                    begin
                        sleep = ns_to_gather(PAGE - tokens, byte_rate, 1'b1);
                        if (sleep > WAIT_CAP)
                            sleep = WAIT_CAP;
                        wait_count = sat_add(wait_count, 64'd1);
                        dec = pwtb_pkg::DEC_WAIT;
                    end
                end
            end
            pwtb_pkg::CMD_RELOAD:
            begin
                byte_rate = (limiter_en && limit_active) ? {32'd0, rate_kib, 10'd0} : 64'd0;
                if (byte_rate == 0)
                    burst = 0;
                else
                    burst = (byte_rate / 8 < PAGE) ? PAGE : byte_rate / 8;
                tokens = burst;
                refill_stamp = now_ns;
            end
            pwtb_pkg::CMD_WAITDONE:
                slept_total = sat_add(slept_total, waited_ns);
            default:
                dec = pwtb_pkg::DEC_ACK;
        endcase
        r.dec = dec;
        r.sleep = sleep[29:0];
        r.tokens = tokens[28:0];
        r.charged = granted;
        r.waits = wait_count;
        r.fg_count = fg_total;
        r.inv_count = inv_total;
        r.slept = slept_total;
    endtask

    function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bucket_result_t r;
        int bad;
        if (!rst_n)
        begin
            limiter_en = 0;
            limit_active = 0;
            rate_kib = 0;
            byte_rate = 0;
            burst = 0;
            tokens = 0;
            refill_stamp = 0;
            granted = 0;
            wait_count = 0;
            fg_total = 0;
            inv_total = 0;
            slept_total = 0;
            expected_results.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pwtb_pkg::REG_ENABLE: limiter_en = cfg_data[0];
                    pwtb_pkg::REG_ACTIVE: limit_active = cfg_data[0];
                    pwtb_pkg::REG_RATE:   rate_kib = cfg_data;
                    default: ;
                endcase
            end
            // The result side is checked first: an expectation made at this
            // edge cannot be the one leaving the block at the same edge.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    errors++;
                end
                else
                begin
                    r = expected_results.pop_front();
                    bad = 0;
                    bad += field_differs("decision", 64'(r.dec), 64'(decision));
                    bad += field_differs("wait_ns", 64'(r.sleep), 64'(wait_ns));
                    bad += field_differs("tokens_left", 64'(r.tokens), 64'(tokens_left));
                    bad += field_differs("charged_bytes", r.charged, charged_bytes);
                    bad += field_differs("wait_events", r.waits, wait_events);
                    bad += field_differs("fg_bypasses", r.fg_count, fg_bypasses);
                    bad += field_differs("invalid_fg_bypasses", r.inv_count,
                                         invalid_fg_bypasses);
                    bad += field_differs("total_wait_ns", r.slept, total_wait_ns);
                    if (bad != 0)
                        errors++;
                    checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                bucket_step(r);
                expected_results.push_back(r);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== tb/page_write_token_bucket_top_tb.sv =====
`timescale 1ns / 1ps

module page_write_token_bucket_top_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int WORD_TARGET = 1050;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_we = 0;
    logic [1:0]         cfg_index = pwtb_pkg::REG_ENABLE;
    logic [21:0]        cfg_data = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [1:0]         command = pwtb_pkg::CMD_REQ;
    logic [63:0]        now_ns = 0;
    logic [31:0]        requester_uid = 0;
    logic signed [31:0] foreground_uid = 0;
    logic               is_background = 0;
    logic [63:0]        waited_ns = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [2:0]         decision;
    logic [29:0]        wait_ns;
    logic [28:0]        tokens_left;
    logic [63:0]        charged_bytes, wait_events, fg_bypasses;
    logic [63:0]        invalid_fg_bypasses, total_wait_ns;

    int  errors, pending, checked;
    int  words_sent = 0;
    int  phases = 0;
    int  cycles = 0;
    int  stall_left = 0;
    bit  calm = 0;
    logic [63:0] clock_ns = 0;

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    page_write_token_bucket_top dut (.*);

    token_bucket_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver stalls in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n || calm)
            out_ready <= 1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            out_ready <= 0;
        end
        else
            out_ready <= 1;
    end

    // Called at a rising edge; returns at the edge that takes the word with
    // in_valid still high, or at a later edge with in_valid dropped.
    task automatic send_word(logic [1:0] cmd, logic [63:0] t, logic [31:0] uid,
                             logic [31:0] fg, logic bg, logic [63:0] slept);
        in_valid <= 1;
        command <= cmd;
        now_ns <= t;
        requester_uid <= uid;
        foreground_uid <= fg;
        is_background <= bg;
        waited_ns <= slept;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic request(logic [63:0] t, logic [31:0] uid, logic [31:0] fg, logic bg);
        send_word(pwtb_pkg::CMD_REQ, t, uid, fg, bg, 64'd0);
    endtask

    task automatic settle_and_configure(logic en, logic act, logic [21:0] rate);
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_we <= 1;
        cfg_index <= pwtb_pkg::REG_ENABLE;
        cfg_data <= {21'd0, en};
        @(posedge clk);
        cfg_index <= pwtb_pkg::REG_ACTIVE;
        cfg_data <= {21'd0, act};
        @(posedge clk);
        cfg_index <= pwtb_pkg::REG_RATE;
        cfg_data <= rate;
        @(posedge clk);
        cfg_we <= 0;
        phases++;
    endtask

    task automatic random_word();
        logic [31:0] uid, fg;
        int pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
            0: clock_ns = clock_ns;
            1: clock_ns = clock_ns + 64'($urandom_range(1, 1000));
            2: clock_ns = clock_ns + 64'($urandom_range(1, 2000000));
            3: clock_ns = clock_ns + 64'($urandom_range(1000000, 1500000000));
            4: clock_ns = clock_ns + 64'($urandom_range(0, 1000)) * 64'd10000000;
            default:
                if ($urandom_range(0, 3) == 0)
                    clock_ns = {$urandom, $urandom};
                else
                    clock_ns = clock_ns + 64'($urandom_range(1, 300000000));
        endcase
        uid = $urandom;
        case ($urandom_range(0, 9))
            0: fg = $urandom | 32'h8000_0000;
            1: fg = uid;
            default: fg = $urandom & 32'h7FFF_FFFF;
        endcase
        if (pick < 80)
            request(clock_ns, uid, fg, $urandom_range(0, 6) != 0);
        else if (pick < 88)
            send_word(pwtb_pkg::CMD_RELOAD, clock_ns, uid, fg, 1'($urandom_range(0, 1)),
                      {$urandom, $urandom});
        else if (pick < 96)
            send_word(pwtb_pkg::CMD_WAITDONE, clock_ns, uid, fg, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom));
        else
            send_word(CMD_UNUSED, clock_ns, uid, fg, 1'($urandom_range(0, 1)),
                      {$urandom, $urandom});
    endtask

    initial
    begin
        logic [21:0] rate;
        int phase_len;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Limiter off from reset, then a reload with nothing enabled.
        request(64'd5, 32'd10, 32'd11, 1'b1);
        send_word(pwtb_pkg::CMD_RELOAD, 64'd5, 32'd0, 32'd0, 1'b0, 64'd0);
        request(64'd6, 32'd10, 32'd11, 1'b1);

        // 4 KiB/s: the burst is exactly one page.
        settle_and_configure(1'b1, 1'b1, 22'd4);
        send_word(pwtb_pkg::CMD_RELOAD, 64'd1000, 32'd0, 32'd0, 1'b0, 64'd0);
        request(64'd1000, 32'd7, 32'hFFFF_FFFF, 1'b1);
        request(64'd1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        request(64'd1000, 32'd7, 32'd8, 1'b0);
        request(64'd1000, 32'd7, 32'd8, 1'b1);
        // Empty bucket, no time passed: a full second of wait.
        request(64'd1000, 32'd7, 32'd8, 1'b1);
        request(64'd500001000, 32'd7, 32'd8, 1'b1);
        // One nanosecond later adds no bytes.
        request(64'd500001001, 32'd7, 32'd8, 1'b1);
        request(64'd400000000, 32'd7, 32'd8, 1'b1);
        request(64'd3000000000, 32'hFFFF_FFFF, 32'd0, 1'b1);
        send_word(pwtb_pkg::CMD_WAITDONE, 64'd0, 32'd0, 32'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0);
        send_word(pwtb_pkg::CMD_WAITDONE, 64'd0, 32'd0, 32'd0, 1'b0, 64'd100);
        send_word(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 1'b1, 64'd1);

        // 1 KiB/s: the wait for a page is capped.
        settle_and_configure(1'b1, 1'b1, 22'd1);
        send_word(pwtb_pkg::CMD_RELOAD, 64'd0, 32'd0, 32'd0, 1'b0, 64'd0);
        request(64'd0, 32'd1, 32'd2, 1'b1);
        request(64'd1, 32'd1, 32'd2, 1'b1);

        // Highest rate, with a full bucket clamped on the next request.
        settle_and_configure(1'b1, 1'b1, 22'h3F_FFFF);
        send_word(pwtb_pkg::CMD_RELOAD, 64'hFFFF_FFFF_FFFF_FF00, 32'd0, 32'd0, 1'b0, 64'd0);
        request(64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd2, 1'b1);
        request(64'd0, 32'd1, 32'd2, 1'b1);

        settle_and_configure(1'b1, 1'b0, 22'd4);
        request(64'd0, 32'd1, 32'd2, 1'b1);
        settle_and_configure(1'b0, 1'b1, 22'd4);
        send_word(pwtb_pkg::CMD_RELOAD, 64'd0, 32'd0, 32'd0, 1'b0, 64'd0);
        request(64'd0, 32'd1, 32'd2, 1'b1);

        while (words_sent < WORD_TARGET)
        begin
            case ($urandom_range(0, 5))
                0: rate = 22'd0;
                1: rate = 22'd1;
                2: rate = 22'h3F_FFFF;
                3: rate = 22'($urandom_range(1, 4194303));
                default: rate = 22'($urandom_range(1, 64));
            endcase
            settle_and_configure($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, rate);
            clock_ns = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom);
            send_word(pwtb_pkg::CMD_RELOAD, clock_ns, $urandom, $urandom, 1'b0, 64'd0);
            phase_len = $urandom_range(30, 90);
            if (words_sent > WORD_TARGET - 150)
                calm = 1;
            repeat (phase_len) random_word();
        end

        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d words over %0d register settings; %0d results compared.",
                 words_sent, phases, checked);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
